// File: hdl/i2cm_pkg.sv
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_READ  = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_WAIT    = 1'b1;

    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd5;
    localparam logic [7:0] ACK_WAIT_RST    = 8'd50;

    // Input word
    typedef struct packed {
        t_func       func;
        logic [6:0]  dev_addr;
        logic [7:0]  reg_addr;
        logic [4:0]  byte_count;
        logic [7:0]  wr_byte;
        logic        sda_sample;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
    } t_out_word;

    // Timing configuration handed to the bus engine
    typedef struct packed {
        logic [7:0] half_period;
        logic [7:0] ack_wait_limit;
    } t_bus_cfg;

endpackage

// File: hdl/i2c_master_register_access.sv
// The result word of an accepted word is registered and appears on the output in the cycle after acceptance.
// Throughput: one word per cycle; a new word is accepted while the result waits
// if the output side takes it in the same cycle.
// Each word is one bus time step; a bus segment lasts half_period tick words (one if half_period is 0).
// Reset (synchronous, active low) returns the bus to idle and the registers to
// half_period 5 and ack_wait_limit 50; the transmit store is not cleared.
module i2c_master_register_access
    import i2cm_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_bus_cfg  r_cfg;
    t_out_word r_out_word;
    t_out_word result;
    logic      r_out_valid;
    logic      accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period    <= HALF_PERIOD_RST;
            r_cfg.ack_wait_limit <= ACK_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg.half_period    <= i_cfg_data;
                CFG_ACK_WAIT:    r_cfg.ack_wait_limit <= i_cfg_data;
                default:         r_cfg.half_period    <= r_cfg.half_period;
            endcase
        end
    end

    i2cm_engine #(
        .MAX_BYTES (MAX_BYTES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output register: load on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= result;
        end
    end

    // Every accepted word yields a result word in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out_valid)
        else $error("accepted word produced no result");

    // An abort is reported only on the word that ends the transaction
    a_error_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.ack_error |-> o_out_word.done_res)
        else $error("ack_error without done");

    // Done leaves the bus idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.done_res |-> !o_out_word.busy_res)
        else $error("done while busy");

    // Received bytes arrive only within a transaction, with the master driving its acknowledge
    a_rx_in_txn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.rx_valid |->
            o_out_word.busy_res && o_out_word.sda_drive)
        else $error("rx byte outside a transaction");

endmodule

// File: hdl/i2cm_engine.sv
// Bus engine: transaction state, transmit store and per-word result logic.
module i2cm_engine
    import i2cm_pkg::*;
#(
    parameter int MAX_BYTES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    input  t_bus_cfg  i_cfg,
    output t_out_word o_result
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int PW = $clog2(MAX_BYTES + 1);
    localparam logic [7:0] MAX_B8 = 8'(MAX_BYTES);
    localparam logic [PW-1:0] MAX_PW = PW'(MAX_BYTES);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_A, PH_ST_B, PH_WB_LOW, PH_WB_HIGH, PH_ACK_LOW,
        PH_ACK_HIGH, PH_RS_A, PH_RB_LOW, PH_RB_HIGH, PH_MA_LOW, PH_MA_HIGH,
        PH_SP_A, PH_SP_B, PH_SP_C
    } t_phase;

    typedef enum logic [1:0] {
        HDR_ADDR, HDR_REG, HDR_READ
    } t_hdr;

    t_phase        r_phase, n_phase;
    t_hdr          r_hdr, n_hdr;
    logic [3:0]    r_bit_index, n_bit_index;
    logic [4:0]    r_byte_index, n_byte_index;
    logic [7:0]    r_shift, n_shift;
    logic [7:0]    r_delay, n_delay;
    logic [7:0]    r_wait, n_wait;
    logic [PW-1:0] r_load_ptr, n_load_ptr;
    logic [6:0]    r_target, n_target;
    logic [7:0]    r_reg_addr, n_reg_addr;
    logic [4:0]    r_count, n_count;
    logic          r_read_mode, n_read_mode;
    logic          r_abort, n_abort;

    logic [7:0]    r_store [MAX_BYTES];
    logic [7:0]    r_tx_rd;
    logic          store_we;

    logic [7:0]    half;
    logic [8:0]    delay_inc;
    logic [4:0]    byte_next;
    logic [5:0]    ma_sum;
    logic [7:0]    rxb;
    logic          rxv, done, err;
    logic          scl, sdl, drv;

    // Next state for one accepted word
    always_comb begin
        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_bit_index  = r_bit_index;
        n_byte_index = r_byte_index;
        n_shift      = r_shift;
        n_delay      = r_delay;
        n_wait       = r_wait;
        n_load_ptr   = r_load_ptr;
        n_target     = r_target;
        n_reg_addr   = r_reg_addr;
        n_count      = r_count;
        n_read_mode  = r_read_mode;
        n_abort      = r_abort;
        store_we     = 1'b0;
        rxb          = 8'd0;
        rxv          = 1'b0;
        done         = 1'b0;
        err          = 1'b0;
        half         = (i_cfg.half_period == 8'd0) ? 8'd1 : i_cfg.half_period;
        delay_inc    = {1'b0, r_delay} + 9'd1;
        byte_next    = r_byte_index + 5'd1;

        case (i_word.func)
            FUNC_LOAD: begin
                if (r_phase == PH_IDLE && r_load_ptr < MAX_PW) begin
                    store_we   = 1'b1;
                    n_load_ptr = r_load_ptr + PW'(1);
                end
            end
            FUNC_WRITE, FUNC_READ: begin
                if (r_phase == PH_IDLE) begin
                    n_target     = i_word.dev_addr;
                    n_reg_addr   = i_word.reg_addr;
                    n_count      = (8'(i_word.byte_count) > MAX_B8) ? 5'(MAX_B8)
                                                                   : i_word.byte_count;
                    n_read_mode  = (i_word.func == FUNC_READ);
                    n_load_ptr   = '0;
                    n_byte_index = 5'd0;
                    n_bit_index  = 4'd0;
                    n_wait       = 8'd0;
                    n_delay      = 8'd0;
                    n_hdr        = HDR_ADDR;
                    n_abort      = 1'b0;
                    n_phase      = PH_ST_A;
                end
            end
            default: begin
                if (r_phase != PH_IDLE) begin
                    if (delay_inc < {1'b0, half}) begin
                        n_delay = delay_inc[7:0];
                    end else begin
                        n_delay = 8'd0;
                        // Segment end: advance the bus phase
                        case (r_phase)
                            PH_ST_A: n_phase = PH_ST_B;
                            PH_ST_B: begin
                                n_bit_index = 4'd0;
                                n_phase     = PH_WB_LOW;
                                if (r_hdr == HDR_ADDR) begin
                                    n_shift = {r_target, 1'b0};
                                end else begin
                                    n_hdr   = HDR_READ;
                                    n_shift = {r_target, 1'b1};
                                end
                            end
                            PH_WB_LOW: n_phase = PH_WB_HIGH;
                            PH_WB_HIGH: begin
                                n_shift     = {r_shift[6:0], 1'b0};
                                n_bit_index = r_bit_index + 4'd1;
                                if (r_bit_index >= 4'd7) begin
                                    n_wait  = 8'd0;
                                    n_phase = PH_ACK_LOW;
                                end else begin
                                    n_phase = PH_WB_LOW;
                                end
                            end
                            PH_ACK_LOW: begin
                                if (!i_word.sda_sample) begin
                                    n_phase = PH_ACK_HIGH;
                                end else begin
                                    if (r_wait != 8'hFF) begin
                                        n_wait = r_wait + 8'd1;
                                    end
                                    if (n_wait > i_cfg.ack_wait_limit) begin
                                        n_abort = 1'b1;
                                        n_phase = PH_SP_A;
                                    end
                                end
                            end
                            PH_ACK_HIGH: begin
                                case (r_hdr)
                                    HDR_ADDR: begin
                                        n_hdr       = HDR_REG;
                                        n_shift     = r_reg_addr;
                                        n_bit_index = 4'd0;
                                        n_phase     = PH_WB_LOW;
                                    end
                                    HDR_REG: begin
                                        if (r_read_mode) begin
                                            n_phase = PH_RS_A;
                                        end else if (r_byte_index < r_count &&
                                                     8'(r_byte_index) < MAX_B8) begin
                                            n_shift      = r_tx_rd;
                                            n_bit_index  = 4'd0;
                                            n_phase      = PH_WB_LOW;
                                            n_byte_index = byte_next;
                                        end else begin
                                            n_phase = PH_SP_A;
                                        end
                                    end
                                    default: begin
                                        n_byte_index = 5'd0;
                                        if (r_count == 5'd0) begin
                                            n_phase = PH_SP_A;
                                        end else begin
                                            n_shift     = 8'd0;
                                            n_bit_index = 4'd0;
                                            n_phase     = PH_RB_LOW;
                                        end
                                    end
                                endcase
                            end
                            PH_RS_A: n_phase = PH_ST_A;
                            PH_RB_LOW: n_phase = PH_RB_HIGH;
                            PH_RB_HIGH: begin
                                n_shift     = {r_shift[6:0], i_word.sda_sample};
                                n_bit_index = r_bit_index + 4'd1;
                                if (r_bit_index >= 4'd7) begin
                                    rxb     = n_shift;
                                    rxv     = 1'b1;
                                    n_phase = PH_MA_LOW;
                                end else begin
                                    n_phase = PH_RB_LOW;
                                end
                            end
                            PH_MA_LOW: n_phase = PH_MA_HIGH;
                            PH_MA_HIGH: begin
                                n_byte_index = byte_next;
                                if (byte_next < r_count) begin
                                    n_shift     = 8'd0;
                                    n_bit_index = 4'd0;
                                    n_phase     = PH_RB_LOW;
                                end else begin
                                    n_phase = PH_SP_A;
                                end
                            end
                            PH_SP_A: n_phase = PH_SP_B;
                            PH_SP_B: n_phase = PH_SP_C;
                            PH_SP_C: begin
                                done    = 1'b1;
                                err     = r_abort;
                                n_abort = 1'b0;
                                n_phase = PH_IDLE;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
        endcase
    end

    // Drive the bus lines from the phase after this word
    always_comb begin
        ma_sum = {1'b0, n_byte_index} + 6'd1;
        scl    = 1'b1;
        sdl    = 1'b0;
        drv    = 1'b1;
        case (n_phase)
            PH_ST_A:     sdl = 1'b1;
            PH_ST_B:     sdl = 1'b0;
            PH_WB_LOW: begin
                scl = 1'b0;
                sdl = n_shift[7];
            end
            PH_WB_HIGH:  sdl = n_shift[7];
            PH_ACK_LOW: begin
                scl = 1'b0;
                drv = 1'b0;
            end
            PH_ACK_HIGH: drv = 1'b0;
            PH_RS_A: begin
                scl = 1'b0;
                sdl = 1'b1;
            end
            PH_RB_LOW: begin
                scl = 1'b0;
                drv = 1'b0;
            end
            PH_RB_HIGH:  drv = 1'b0;
            PH_MA_LOW: begin
                scl = 1'b0;
                sdl = (ma_sum >= {1'b0, n_count});
            end
            PH_MA_HIGH:  sdl = (ma_sum >= {1'b0, n_count});
            PH_SP_A:     scl = 1'b0;
            PH_SP_B:     sdl = 1'b0;
            PH_SP_C:     sdl = 1'b1;
            default:     drv = 1'b0;
        endcase
    end

    assign o_result = '{
        scl_level: scl,
        sda_level: sdl & drv,
        sda_drive: drv,
        rx_byte:   rxb,
        rx_valid:  rxv,
        busy_res:  (n_phase != PH_IDLE),
        done_res:  done,
        ack_error: err
    };

    // Hold transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_hdr        <= HDR_ADDR;
            r_bit_index  <= 4'd0;
            r_byte_index <= 5'd0;
            r_shift      <= 8'd0;
            r_delay      <= 8'd0;
            r_wait       <= 8'd0;
            r_load_ptr   <= '0;
            r_target     <= 7'd0;
            r_reg_addr   <= 8'd0;
            r_count      <= 5'd0;
            r_read_mode  <= 1'b0;
            r_abort      <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_hdr        <= n_hdr;
            r_bit_index  <= n_bit_index;
            r_byte_index <= n_byte_index;
            r_shift      <= n_shift;
            r_delay      <= n_delay;
            r_wait       <= n_wait;
            r_load_ptr   <= n_load_ptr;
            r_target     <= n_target;
            r_reg_addr   <= n_reg_addr;
            r_count      <= n_count;
            r_read_mode  <= n_read_mode;
            r_abort      <= n_abort;
        end
    end

    // Transmit store: write on load, prefetch the byte at the current index
    always_ff @(posedge i_clk) begin
        if (i_step && store_we) begin
            r_store[AW'(r_load_ptr)] <= i_word.wr_byte;
        end
        if (8'(r_byte_index) < MAX_B8) begin
            r_tx_rd <= r_store[AW'(r_byte_index)];
        end
    end

endmodule
